### rtl/plti_pkg.sv
// Shared types and constants for the piecewise linear table interpolator.
// Used by the channel interfaces, the table memory, the divider and the top level.
// No dependencies.
`default_nettype none

package plti_pkg;

   // field widths
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 4;
   localparam int CSR_W    = 5;
   localparam int KIND_W   = 3;

   // default number of table slots
   localparam int DEFAULT_TABLE_DEPTH = 16;

   typedef logic [KIND_W-1:0] kind_type;

   // item function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // result kinds
   localparam kind_type KIND_CLAMP_LOW  = 3'd0;
   localparam kind_type KIND_CLAMP_HIGH = 3'd1;
   localparam kind_type KIND_EXACT      = 3'd2;
   localparam kind_type KIND_INTERP     = 3'd3;
   localparam kind_type KIND_EMPTY      = 3'd4;
   localparam kind_type KIND_NO_SEGMENT = 3'd5;

   // one breakpoint as stored in the table
   typedef struct packed {
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
   } entry_type;

   // interpolation request to the divider
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] dq;    // query minus left x, unsigned
      logic [DATA_W-1:0] dx;    // segment width, unsigned, nonzero
      logic [DATA_W-1:0] mag;   // magnitude of segment rise
      logic              neg;   // segment falls
      logic [DATA_W-1:0] base;  // left y
   } div_cmd_type;

   // interpolation answer from the divider
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] value;
   } div_rsp_type;

endpackage

`default_nettype wire

### rtl/plti_if.sv
// Valid/ready channel interfaces for request items and response items.
// Depends on plti_pkg.
`default_nettype none

interface plti_req_if;
   import plti_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [INDEX_W-1:0]       point_index;
   logic signed [DATA_W-1:0] point_x;
   logic signed [DATA_W-1:0] point_y;
   logic signed [DATA_W-1:0] query_value;

   modport source (output valid, func, point_index, point_x, point_y, query_value,
                   input ready);
   modport sink (input valid, func, point_index, point_x, point_y, query_value,
                 output ready);
endinterface

interface plti_rsp_if;
   import plti_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] estimate;
   logic [KIND_W-1:0]        result_kind;

   modport source (output valid, estimate, result_kind, input ready);
   modport sink (input valid, estimate, result_kind, output ready);
endinterface

`default_nettype wire

### rtl/piecewise_linear_table_interpolator.sv
// Piecewise linear interpolator over a table of signed Q16.16 breakpoints.
// A write item stores one breakpoint and gives no response. A query item gives
// one response: an empty table goes straight to the done state, a query that
// clamps at either end is settled once the first and last points are read,
// and a query inside a segment waits for the walk and the divider. The walk reads
// one table entry per cycle through the single read port of the table memory,
// and the divider of the interpolation unit makes one quotient bit per cycle.
// One item is worked on at a time; the next item is taken as soon as the
// response sits in the output register. The table has no reset: a query must
// only touch slots that were written. points_in_use above the depth acts as
// the depth; writes to slots at or above the depth are dropped.
// Depends on plti_pkg, plti_if, plti_table_mem and plti_muldiv.
`default_nettype none

module piecewise_linear_table_interpolator #(
   parameter int TABLE_DEPTH = plti_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   plti_req_if.sink                          req_ch,
   plti_rsp_if.source                        rsp_ch,
   input  wire logic                         csr_wr_en,
   input  wire logic [plti_pkg::CSR_W-1:0]   csr_wr_data
);
   import plti_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int SLOT_W = (INDEX_W > CNT_W) ? INDEX_W + 1 : CNT_W + 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HEAD = 3'd1;
   localparam logic [2:0] S_TAIL = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   // control and item registers
   logic [2:0]               state_ff, state_in;
   logic [CSR_W-1:0]         points_ff;
   logic signed [DATA_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [DATA_W-1:0] ax_ff, ax_in;
   logic signed [DATA_W-1:0] ay_ff, ay_in;
   logic signed [DATA_W-1:0] res_est_ff, res_est_in;
   kind_type                 res_kind_ff, res_kind_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_est_ff, rsp_est_in;
   kind_type                 rsp_kind_ff, rsp_kind_in;

   // table and divider connections
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   div_cmd_type      div_cmd;
   div_rsp_type      div_rsp;

   logic                     accept;
   logic                     slot_ok;
   logic [CMP_W-1:0]         points_ext;
   logic [CMP_W-1:0]         n_sat;
   logic [IDX_W-1:0]         last_idx;
   logic signed [DATA_W-1:0] bx;
   logic signed [DATA_W-1:0] by;
   logic signed [DATA_W:0]   dy;
   logic                     out_free;

   plti_table_mem #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   plti_muldiv u_muldiv (
      .clock(clock),
      .reset(reset),
      .start(div_cmd),
      .done (div_rsp)
   );

   // input handshake and table writes
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign slot_ok      = SLOT_W'(req_ch.point_index) < SLOT_W'(TABLE_DEPTH);
   assign wr_en        = accept && (req_ch.func == FUNC_WRITE) && slot_ok;
   assign wr_addr      = IDX_W'(req_ch.point_index);
   assign wr_data.x    = req_ch.point_x;
   assign wr_data.y    = req_ch.point_y;

   // points in use, saturated at the depth
   assign points_ext = CMP_W'(points_ff);
   assign n_sat      = (points_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : points_ext;
   assign last_idx   = IDX_W'(n_ff - CNT_W'(1));

   // right end of the segment under test
   assign bx = $signed(rd_data.x);
   assign by = $signed(rd_data.y);
   assign dy = {by[DATA_W-1], by} - {ay_ff[DATA_W-1], ay_ff};

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // query sequencer
   always_comb begin
      state_in    = state_ff;
      q_in        = q_ff;
      n_in        = n_ff;
      idx_in      = idx_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      res_est_in  = res_est_ff;
      res_kind_in = res_kind_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      div_cmd     = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_ch.func == FUNC_QUERY)) begin
               q_in = req_ch.query_value;
               n_in = CNT_W'(n_sat);
               if (n_sat == '0) begin
                  res_est_in  = '0;
                  res_kind_in = KIND_EMPTY;
                  state_in    = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            // first point arrives, fetch the last one in use
            ax_in    = bx;
            ay_in    = by;
            rd_en    = 1'b1;
            rd_addr  = last_idx;
            state_in = S_TAIL;
         end
         S_TAIL: begin
            if (q_ff <= ax_ff) begin
               res_est_in  = ay_ff;
               res_kind_in = KIND_CLAMP_LOW;
               state_in    = S_DONE;
            end else if (q_ff >= bx) begin
               res_est_in  = by;
               res_kind_in = KIND_CLAMP_HIGH;
               state_in    = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(1);
               idx_in   = IDX_W'(1);
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // left point in ax/ay, right point on the read port
            if (q_ff == ax_ff) begin
               res_est_in  = ay_ff;
               res_kind_in = KIND_EXACT;
               state_in    = S_DONE;
            end else if ((q_ff > ax_ff) && (q_ff < bx)) begin
               div_cmd.valid = 1'b1;
               div_cmd.dq    = q_ff - ax_ff;
               div_cmd.dx    = bx - ax_ff;
               div_cmd.neg   = dy[DATA_W];
               div_cmd.mag   = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
               div_cmd.base  = ay_ff;
               state_in      = S_DIV;
            end else if (idx_ff == last_idx) begin
               res_est_in  = '0;
               res_kind_in = KIND_NO_SEGMENT;
               state_in    = S_DONE;
            end else begin
               ax_in   = bx;
               ay_in   = by;
               idx_in  = idx_ff + IDX_W'(1);
               rd_en   = 1'b1;
               rd_addr = idx_ff + IDX_W'(1);
            end
         end
         S_DIV: begin
            if (div_rsp.valid) begin
               res_est_in  = div_rsp.value;
               res_kind_in = KIND_INTERP;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_est_in   = rsp_est_ff;
      rsp_kind_in  = rsp_kind_ff;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_est_in   = res_est_ff;
         rsp_kind_in  = res_kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         points_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            points_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      res_est_ff  <= res_est_in;
      res_kind_ff <= res_kind_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.estimate    = rsp_est_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;

   // checks
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> CNT_W'(idx_ff) < n_ff)
      else $error("segment walk ran past the points in use");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(state_ff) == S_DONE)
      else $error("response loaded outside the done state");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.result_kind == KIND_EMPTY) |-> rsp_ch.estimate == '0)
      else $error("empty table response with nonzero estimate");

   a_div_answer_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.valid |-> state_ff == S_DIV)
      else $error("divider answer while not waiting for it");

endmodule

`default_nettype wire

### rtl/plti_table_mem.sv
// Breakpoint table: one write port, one read port with registered read data.
// Depends on plti_pkg.
`default_nettype none

module plti_table_mem #(
   parameter int TABLE_DEPTH = plti_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  wire plti_pkg::entry_type            wr_data,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output plti_pkg::entry_type                 rd_data
);
   import plti_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/plti_muldiv.sv
// Segment interpolation unit: one 32x32 multiply, then a restoring divide
// that produces one quotient bit per cycle, then the add to or subtraction from the left y.
// Depends on plti_pkg.
`default_nettype none

module plti_muldiv (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire plti_pkg::div_cmd_type start,
   output plti_pkg::div_rsp_type      done
);
   import plti_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_MUL  = 2'd1;
   localparam logic [1:0] M_DIV  = 2'd2;
   localparam logic [1:0] M_FIN  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [DATA_W-1:0] dq_ff, dq_in;
   logic [DATA_W-1:0] dx_ff, dx_in;
   logic [DATA_W-1:0] mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] base_ff, base_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] low_ff, low_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [2*DATA_W-1:0] prod;
   logic [DATA_W:0]     shifted;
   logic [DATA_W+1:0]   trial;
   logic                qbit;

   // product and one restoring step
   assign prod    = dq_ff * mag_ff;
   assign shifted = {rem_ff, low_ff[DATA_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dx_ff};
   assign qbit    = ~trial[DATA_W+1];

   // sequencing
   always_comb begin
      state_in = state_ff;
      dq_in    = dq_ff;
      dx_in    = dx_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      base_in  = base_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         M_IDLE: begin
            if (start.valid) begin
               dq_in    = start.dq;
               dx_in    = start.dx;
               mag_in   = start.mag;
               neg_in   = start.neg;
               base_in  = start.base;
               state_in = M_MUL;
            end
         end
         M_MUL: begin
            // high half is already below the divisor, so the quotient fits 32 bits
            rem_in   = prod[2*DATA_W-1:DATA_W];
            low_in   = prod[DATA_W-1:0];
            cnt_in   = '1;
            state_in = M_DIV;
         end
         M_DIV: begin
            rem_in = qbit ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
            low_in = {low_ff[DATA_W-2:0], qbit};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = M_FIN;
            end
         end
         M_FIN: begin
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff   <= dq_in;
      dx_ff   <= dx_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      base_ff <= base_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      cnt_ff  <= cnt_in;
   end

   // low_ff holds the quotient once the divide is through
   assign done.valid = (state_ff == M_FIN);
   assign done.value = neg_ff ? (base_ff - low_ff) : (base_ff + low_ff);

   // checks
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == M_DIV |-> rem_ff < dx_ff)
      else $error("divider remainder not below divisor");

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      start.valid |-> state_ff == M_IDLE)
      else $error("divider started while busy");

endmodule

`default_nettype wire

### dv/piecewise_linear_table_interpolator_test.sv
// Self-checking testbench for the piecewise linear table interpolator.
// Drives breakpoint writes and queries, predicts every estimate and checks each response.
// Depends on plti_pkg, plti_if and the piecewise_linear_table_interpolator top level.
`default_nettype none

module piecewise_linear_table_interpolator_test;
   import plti_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int DRAIN_HOLD     = 8;
   localparam int END_HOLD       = 80;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam longint Q_MIN = -64'sd2147483648;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint SPAN_FULL = 64'sd4294967295;

   // one request item as driven on the channel
   typedef struct {
      logic                     func;
      logic [INDEX_W-1:0]       point_index;
      logic signed [DATA_W-1:0] point_x;
      logic signed [DATA_W-1:0] point_y;
      logic signed [DATA_W-1:0] query_value;
   } req_item_type;

   // one response as predicted or observed
   typedef struct packed {
      logic [DATA_W-1:0] value;
      kind_type          kind;
   } estimate_type;

   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_LONG_STALLS
   } ready_mode_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   plti_req_if req_ch ();
   plti_rsp_if rsp_ch ();

   piecewise_linear_table_interpolator #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state: breakpoint table and active point count
   logic signed [DATA_W-1:0] knot_x [TABLE_DEPTH] = '{default: '0};
   logic signed [DATA_W-1:0] knot_y [TABLE_DEPTH] = '{default: '0};
   logic [CSR_W-1:0]         active_points = '0;

   estimate_type expected_estimates [$];
   int           mismatches = 0;
   int           items_sent = 0;
   int           burst_left = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned rand64();
      return {$urandom, $urandom};
   endfunction

   // expected estimate for a query against the current table
   function automatic estimate_type predict_estimate(input logic signed [DATA_W-1:0] query);
      estimate_type r;
      int           used, i;
      longint       q, xa, xb, ya, yb, dy, est;
      logic [63:0]  dq, dx, mag, quo;
      used   = (active_points > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_points);
      q      = query;
      r.value = '0;
      r.kind  = KIND_NO_SEGMENT;
      if (used == 0) begin
         r.kind = KIND_EMPTY;
      end else if (q <= knot_x[0]) begin
         r.value = knot_y[0];
         r.kind  = KIND_CLAMP_LOW;
      end else if (q >= knot_x[used-1]) begin
         r.value = knot_y[used-1];
         r.kind  = KIND_CLAMP_HIGH;
      end else begin
         // walk segments in order, first hit wins
         for (i = 1; i < used && r.kind == KIND_NO_SEGMENT; i++) begin
            xa = knot_x[i-1];
            xb = knot_x[i];
            ya = knot_y[i-1];
            yb = knot_y[i];
            if (q == xa) begin
               r.value = knot_y[i-1];
               r.kind  = KIND_EXACT;
            end else if (q > xa && q < xb) begin
               // exact product, quotient truncated toward zero
               dq  = q - xa;
               dx  = xb - xa;
               dy  = yb - ya;
               mag = (dy < 0) ? -dy : dy;
               quo = (dq * mag) / dx;
               est = (dy < 0) ? ya - longint'(quo) : ya + longint'(quo);
               r.value = est[DATA_W-1:0];
               r.kind  = KIND_INTERP;
            end
         end
      end
      return r;
   endfunction

   function automatic req_item_type breakpoint_write(input int slot, input longint x,
                                                     input longint y);
      req_item_type it;
      it.func        = FUNC_WRITE;
      it.point_index = slot[INDEX_W-1:0];
      it.point_x     = x[DATA_W-1:0];
      it.point_y     = y[DATA_W-1:0];
      it.query_value = $urandom;
      return it;
   endfunction

   function automatic req_item_type breakpoint_query(input longint q);
      req_item_type it;
      it.func        = FUNC_QUERY;
      it.point_index = INDEX_W'($urandom);
      it.point_x     = $urandom;
      it.point_y     = $urandom;
      it.query_value = q[DATA_W-1:0];
      return it;
   endfunction

   // send one item in bursts with random gaps, then update the predictor
   task automatic send_item(input req_item_type item);
      bit taken;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= item.func;
      req_ch.point_index <= item.point_index;
      req_ch.point_x     <= item.point_x;
      req_ch.point_y     <= item.point_y;
      req_ch.query_value <= item.query_value;
      do begin
         @(negedge clock);
         taken = (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
         @(posedge clock);
      end while (!taken);
      burst_left--;
      items_sent++;
      if (item.func == FUNC_WRITE) begin
         knot_x[item.point_index] = item.point_x;
         knot_y[item.point_index] = item.point_y;
      end else begin
         expected_estimates.push_back(predict_estimate(item.query_value));
      end
   endtask

   // hold the sender until every estimate is back and a write has settled
   task automatic wait_until_idle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (DRAIN_HOLD) @(posedge clock);
   endtask

   task automatic write_active_points(input int count);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count[CSR_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_points = count[CSR_W-1:0];
   endtask

   // write a fresh table into slots 0 .. count-1, mostly strictly increasing
   task automatic load_table(input int count);
      longint xs [TABLE_DEPTH];
      longint ys [TABLE_DEPTH];
      longint span, room, low, y_base, held;
      int     x_shape, y_shape, i, j;
      bit     backward;
      x_shape  = $urandom_range(0, 9);
      y_shape  = $urandom_range(0, 3);
      backward = $urandom_range(0, 1);
      case ($urandom_range(0, 3))
         0: span = 2 * count;
         1: span = $urandom_range(16, 4096);
         2: span = $urandom;
         default: span = SPAN_FULL - count;
      endcase
      if (span > SPAN_FULL - count) span = SPAN_FULL - count;
      room = SPAN_FULL - span - count;
      low  = Q_MIN + longint'(rand64() % (room + 1));
      for (i = 0; i < count; i++) begin
         if (x_shape == 0) xs[i] = longint'(int'($urandom));
         else xs[i] = low + longint'(rand64() % (span + 1));
      end
      // sort and force strictly increasing, except for the noise shape
      if (x_shape != 0) begin
         for (i = 1; i < count; i++) begin
            held = xs[i];
            for (j = i; j > 0 && xs[j-1] > held; j--) xs[j] = xs[j-1];
            xs[j] = held;
         end
         for (i = 1; i < count; i++) begin
            if (xs[i] <= xs[i-1]) xs[i] = xs[i-1] + 1;
         end
      end
      y_base = longint'(int'($urandom));
      for (i = 0; i < count; i++) begin
         case (y_shape)
            0: ys[i] = longint'(int'($urandom));
            1: ys[i] = y_base + longint'($urandom_range(0, 512)) - 256;
            2: ys[i] = y_base;
            default: ys[i] = ($urandom_range(0, 1) == 1) ? Q_MAX : Q_MIN;
         endcase
      end
      for (i = 0; i < count; i++) begin
         j = backward ? count - 1 - i : i;
         send_item(breakpoint_write(j, xs[j], ys[j]));
      end
   endtask

   // query value aimed at breakpoints, segment interiors, ends and extremes
   function automatic longint pick_query(input int used);
      int     k;
      longint lo, hi;
      k  = (used > 1) ? $urandom_range(0, used - 2) : 0;
      lo = knot_x[k];
      hi = knot_x[k+1];
      case ($urandom_range(0, 7))
         0: return knot_x[$urandom_range(0, (used > 0) ? used - 1 : 0)];
         1: return ($urandom_range(0, 1) == 1) ? lo + 1 : lo - 1;
         2, 3, 4: begin
            if (hi - lo > 1) return lo + 1 + longint'(rand64() % (hi - lo - 1));
            return lo;
         end
         5: return longint'(int'($urandom));
         6: return ($urandom_range(0, 1) == 1) ? Q_MAX : Q_MIN;
         default: begin
            if ($urandom_range(0, 1) == 1) return knot_x[0] - $urandom_range(0, 1000);
            return knot_x[(used > 0) ? used - 1 : 0] + $urandom_range(0, 1000);
         end
      endcase
   endfunction

   // empty table: every query gives zero with the empty status
   task automatic test_empty_table();
      write_active_points(0);
      send_item(breakpoint_query(Q_MIN));
      send_item(breakpoint_query(Q_MAX));
   endtask

   // full-range table: clamps at both ends, exact breakpoints, steep segments
   task automatic test_clamp_exact_interp();
      write_active_points(4);
      send_item(breakpoint_write(0, Q_MIN, Q_MAX));
      send_item(breakpoint_write(1, -1, Q_MIN));
      send_item(breakpoint_write(2, 0, 64'sh7FFF_0000));
      send_item(breakpoint_write(3, Q_MAX, Q_MIN));
      send_item(breakpoint_query(Q_MIN));
      send_item(breakpoint_query(Q_MAX));
      send_item(breakpoint_query(-1));
      send_item(breakpoint_query(0));
      send_item(breakpoint_query(-64'sd1073741824));
      send_item(breakpoint_query(1));
      send_item(breakpoint_query(Q_MIN + 1));
   endtask

   // single point: clamp low at or below it, clamp high above it
   task automatic test_single_point();
      write_active_points(1);
      send_item(breakpoint_write(0, 64'sh0001_0000, 64'sh1234_5678));
      send_item(breakpoint_query(0));
      send_item(breakpoint_query(64'sh0001_0000));
      send_item(breakpoint_query(64'sh0001_0001));
   endtask

   // table not increasing: the walk takes the first segment that holds the query; one query clamps low
   task automatic test_non_increasing_table();
      write_active_points(3);
      send_item(breakpoint_write(0, 0, 64'sh000A_0000));
      send_item(breakpoint_write(1, -64'sh100, 64'sh0014_0000));
      send_item(breakpoint_write(2, 64'sh1000, 64'sh001E_0000));
      send_item(breakpoint_query(64'sh800));
      send_item(breakpoint_query(-64'sh80));
   endtask

   // phases of random tables and queries under changing point counts
   task automatic test_random_phases();
      int phase, setting, used, queries, n, slot, pick;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (phase == 0) setting = TABLE_DEPTH;
         else if (phase == 1) setting = 31;
         else if (pick == 0) setting = 0;
         else if (pick == 1) setting = 1;
         else if (pick < 4) setting = TABLE_DEPTH;
         else if (pick == 4) setting = $urandom_range(TABLE_DEPTH + 1, 31);
         else setting = $urandom_range(2, TABLE_DEPTH - 1);
         write_active_points(setting);
         used = (setting > TABLE_DEPTH) ? TABLE_DEPTH : setting;
         load_table(used);
         queries = $urandom_range(8, 40);
         for (n = 0; n < queries; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               // rewrite a slot: used slots keep their x so the table stays ordered
               slot = $urandom_range(0, TABLE_DEPTH - 1);
               if (slot < used)
                  send_item(breakpoint_write(slot, knot_x[slot], longint'(int'($urandom))));
               else
                  send_item(breakpoint_write(slot, longint'(int'($urandom)),
                                             longint'(int'($urandom))));
            end else begin
               send_item(breakpoint_query(pick_query(used)));
            end
         end
         phase++;
      end
   endtask

   // stimulus and end of run
   initial begin : stimulus
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= FUNC_WRITE;
      req_ch.point_index <= '0;
      req_ch.point_x     <= '0;
      req_ch.point_y     <= '0;
      req_ch.query_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_clamp_exact_interp();
      test_single_point();
      test_non_increasing_table();
      test_random_phases();
      wait_until_idle();
      repeat (END_HOLD) @(posedge clock);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // response stall pattern in randomly chosen modes
   initial begin : rsp_stall_pattern
      ready_mode_type mode;
      int             span, run;
      logic           level;
      rsp_ch.ready <= 1'b0;
      run   = 0;
      level = 1'b1;
      forever begin
         mode = ready_mode_type'($urandom_range(0, 3));
         span = $urandom_range(32, 200);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               READY_ALWAYS: rsp_ch.ready <= 1'b1;
               READY_HALF:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               READY_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: begin
                  if (run == 0) begin
                     level = ~level;
                     run   = level ? $urandom_range(1, 4) : $urandom_range(4, 24);
                  end
                  run--;
                  rsp_ch.ready <= level;
               end
            endcase
         end
      end
   end

   // compare each accepted response with the oldest expected estimate
   initial begin : estimate_checker
      estimate_type seen, want;
      forever begin
         @(negedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            seen.value = rsp_ch.estimate;
            seen.kind  = rsp_ch.result_kind;
            if (expected_estimates.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual estimate %h kind %0d",
                        $time, seen.value, seen.kind);
               mismatches++;
            end else begin
               want = expected_estimates.pop_front();
               if (seen.value !== want.value) begin
                  $display("%0t: estimate mismatch, expected %h, actual %h",
                           $time, want.value, seen.value);
                  mismatches++;
               end
               if (seen.kind !== want.kind) begin
                  $display("%0t: result_kind mismatch, expected %0d, actual %0d",
                           $time, want.kind, seen.kind);
                  mismatches++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: watchdog expired after %0d idle cycles", $time, WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
rtl/plti_pkg.sv
rtl/plti_if.sv
rtl/plti_table_mem.sv
rtl/plti_muldiv.sv
rtl/piecewise_linear_table_interpolator.sv
dv/piecewise_linear_table_interpolator_test.sv
